>>> rtl/core/brbks_pkg.sv
// ----------------------------------------------------------------------------
// brbks_pkg
// Shared types and constants of the byte ring buffer with key search.
// ----------------------------------------------------------------------------
package brbks_pkg;

   // depth must be a power of two
   localparam int DEPTH       = 4096;
   localparam int MAX_REQUEST = 64;
   localparam int PTR_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(MAX_REQUEST + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QIDX_W      = $clog2(QUEUE_DEPTH);

   localparam int CMD_W    = 3;
   localparam int REQ_CNT_W = 7;
   localparam int FIELD_W  = 12;
   localparam int KEY_W    = 64;
   localparam int KLEN_W   = 4;
   localparam int KEY_MAX  = 8;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] REG_KEY_BYTES = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_LEN   = 1'd1;

   localparam logic [KEY_W-1:0]  KEY_BYTES_RESET = 64'd16777216;
   localparam logic [KLEN_W-1:0] KEY_LEN_RESET   = 4'd4;

   localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SKIP   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_EMPTY     = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef enum logic [2:0] {
      OP_WRITE  = 3'd0,
      OP_READ   = 3'd1,
      OP_PEEK   = 3'd2,
      OP_SKIP   = 3'd3,
      OP_SEARCH = 3'd4,
      OP_CLEAR  = 3'd5
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [7:0]         data_byte;
      logic               burst_end;
      logic [CNT_W-1:0]   count;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_head_type;

   function automatic logic [FIELD_W-1:0] sat12(input logic [31:0] v);
      return (v > 32'd4095) ? 12'hFFF : v[FIELD_W-1:0];
   endfunction

endpackage

>>> rtl/core/brbks_req_if.sv
// ----------------------------------------------------------------------------
// brbks_req_if
// Request channel: command items into the buffer.
// ----------------------------------------------------------------------------
interface brbks_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] cmd;
   logic [7:0] data_byte;
   logic       burst_end;
   logic [6:0] count;

   modport source (output valid, cmd, data_byte, burst_end, count, input ready);
   modport sink   (input valid, cmd, data_byte, burst_end, count, output ready);
endinterface

>>> rtl/core/brbks_rsp_if.sv
// ----------------------------------------------------------------------------
// brbks_rsp_if
// Response channel: result items out of the buffer.
// ----------------------------------------------------------------------------
interface brbks_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        byte_valid;
   logic        final_item;
   logic [1:0]  status;
   logic [11:0] amount;
   logic [11:0] match_offset;
   logic [11:0] fill_count;

   modport source (output valid, out_byte, byte_valid, final_item, status, amount,
                   match_offset, fill_count, input ready);
   modport sink   (input valid, out_byte, byte_valid, final_item, status, amount,
                   match_offset, fill_count, output ready);
endinterface

>>> rtl/core/brbks_front.sv
// ----------------------------------------------------------------------------
// brbks_front
// Accepts requests, decodes the command, clamps the count and queues them.
// ----------------------------------------------------------------------------
module brbks_front
   import brbks_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   brbks_req_if.sink      req_ch,
   input  logic           pop,
   output queue_head_type head
);

   entry_type               q_ff [QUEUE_DEPTH];
   logic [QIDX_W-1:0]       wr_idx_ff, wr_idx_in;
   logic [QIDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic [QIDX_W:0]         cnt_ff, cnt_in;
   logic                    take;
   logic                    known;
   entry_type               dec;

   assign req_ch.ready = (cnt_ff != (QIDX_W+1)'(QUEUE_DEPTH));
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      known         = 1'b1;
      dec.op        = OP_WRITE;
      dec.data_byte = req_ch.data_byte;
      dec.burst_end = req_ch.burst_end;
      dec.count     = (req_ch.count > REQ_CNT_W'(MAX_REQUEST)) ?
                      CNT_W'(MAX_REQUEST) : CNT_W'(req_ch.count);
      unique case (req_ch.cmd)
         CMD_WRITE:  dec.op = OP_WRITE;
         CMD_READ:   dec.op = OP_READ;
         CMD_PEEK:   dec.op = OP_PEEK;
         CMD_SKIP:   dec.op = OP_SKIP;
         CMD_SEARCH: dec.op = OP_SEARCH;
         CMD_CLEAR:  dec.op = OP_CLEAR;
         default:    known  = 1'b0;
      endcase
   end

   // unused commands are taken and dropped here
   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      cnt_in    = cnt_ff;
      if (take && known) begin
         wr_idx_in = wr_idx_ff + 1'b1;
         cnt_in    = cnt_in + 1'b1;
      end
      if (pop) begin
         rd_idx_in = rd_idx_ff + 1'b1;
         cnt_in    = cnt_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && known) begin
         q_ff[wr_idx_ff] <= dec;
      end
   end

   assign head.valid = (cnt_ff != '0);
   assign head.entry = q_ff[rd_idx_ff];

endmodule

>>> rtl/core/brbks_back.sv
// ----------------------------------------------------------------------------
// brbks_back
// Executes queued commands on the byte store and drives the result register.
// ----------------------------------------------------------------------------
module brbks_back
   import brbks_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  queue_head_type    head,
   output logic              pop,
   input  logic [KEY_W-1:0]  key_bytes,
   input  logic [KLEN_W-1:0] key_len,
   brbks_rsp_if.source       rsp_ch
);

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_RD_ADDR = 5'b00010,
      S_RD_DATA = 5'b00100,
      S_SR_ADDR = 5'b01000,
      S_SR_DATA = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   fill_ff, fill_in;
   logic [PTR_W-1:0]   cursor_ff, cursor_in;
   logic [FIELD_W-1:0] burst_ff, burst_in;
   logic               drop_ff, drop_in;

   logic [PTR_W-1:0]   base_ff, base_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic [PTR_W-1:0]   pos_ff, pos_in;
   logic [PTR_W-1:0]   avail_ff, avail_in;
   logic [KLEN_W-1:0]  len_ff, len_in;
   logic [KEY_W-1:0]   win_ff, win_in;

   logic [7:0]         mem [DEPTH];
   logic [7:0]         rdata_ff;
   logic               mem_we, mem_re;
   logic [PTR_W-1:0]   mem_waddr, mem_raddr;

   logic               rsp_valid_ff;
   logic [7:0]         o_byte_ff;
   logic               o_bv_ff, o_fin_ff;
   logic [1:0]         o_st_ff;
   logic [FIELD_W-1:0] o_amt_ff, o_mo_ff, o_fill_ff;

   logic               out_free;
   logic               emit, e_bv, e_fin;
   logic [7:0]         e_byte;
   logic [1:0]         e_st;
   logic [FIELD_W-1:0] e_amt, e_mo;

   logic [PTR_W-1:0]   nxt_wr, cur_gap, cur_eff, av;
   logic [CNT_W-1:0]   n_req;
   logic [KLEN_W-1:0]  len_eff;
   logic [FIELD_W-1:0] bc;
   logic               dr, hit;
   logic [PTR_W-1:0]   pos_next;
   logic [2:0]         widx;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      if (key_len == '0) begin
         len_eff = KLEN_W'(1);
      end else if (key_len > KLEN_W'(KEY_MAX)) begin
         len_eff = KLEN_W'(KEY_MAX);
      end else begin
         len_eff = key_len;
      end
   end

   assign nxt_wr = wr_ptr_ff + 1'b1;
   assign n_req  = (32'(fill_ff) < 32'(head.entry.count)) ? CNT_W'(fill_ff) : head.entry.count;
   assign cur_gap = cursor_ff - rd_ptr_ff;
   assign cur_eff = (cur_gap > fill_ff) ? rd_ptr_ff : cursor_ff;
   assign av     = (cur_gap > fill_ff) ? fill_ff : fill_ff - cur_gap;
   assign pos_next = pos_ff + 1'b1;

   // window holds the newest byte in its low lane
   assign win_in = {win_ff[KEY_W-9:0], rdata_ff};

   always_comb begin
      hit = 1'b1;
      for (int j = 0; j < KEY_MAX; j++) begin
         widx = 3'(len_ff - KLEN_W'(1) - KLEN_W'(j));
         if (KLEN_W'(j) < len_ff &&
             win_in[8*widx +: 8] != key_bytes[8*j +: 8]) begin
            hit = 1'b0;
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      fill_in   = fill_ff;
      cursor_in = cursor_ff;
      burst_in  = burst_ff;
      drop_in   = drop_ff;
      base_in   = base_ff;
      n_in      = n_ff;
      k_in      = k_ff;
      pos_in    = pos_ff;
      avail_in  = avail_ff;
      len_in    = len_ff;
      pop       = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = nxt_wr;
      mem_re    = 1'b0;
      mem_raddr = base_ff + PTR_W'(k_ff) + 1'b1;
      emit      = 1'b0;
      e_byte    = '0;
      e_bv      = 1'b0;
      e_fin     = 1'b1;
      e_st      = ST_OK;
      e_amt     = '0;
      e_mo      = '0;
      bc        = burst_ff;
      dr        = drop_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (head.valid && out_free) begin
               pop = 1'b1;
               case (head.entry.op) inside
                  OP_WRITE: begin
                     if (nxt_wr == rd_ptr_ff) begin
                        dr = 1'b1;
                     end else begin
                        mem_we    = 1'b1;
                        wr_ptr_in = nxt_wr;
                        fill_in   = fill_ff + 1'b1;
                        if (burst_ff != '1) begin
                           bc = burst_ff + 1'b1;
                        end
                     end
                     burst_in = bc;
                     drop_in  = dr;
                     if (head.entry.burst_end) begin
                        emit     = 1'b1;
                        e_st     = dr ? ST_FULL : ST_OK;
                        e_amt    = bc;
                        burst_in = '0;
                        drop_in  = 1'b0;
                     end
                  end
                  OP_READ, OP_PEEK, OP_SKIP: begin
                     if (head.entry.op != OP_PEEK && fill_ff != '0) begin
                        rd_ptr_in = rd_ptr_ff + PTR_W'(n_req);
                        fill_in   = fill_ff - PTR_W'(n_req);
                        cursor_in = rd_ptr_in;
                     end
                     if (n_req == '0 || head.entry.op == OP_SKIP) begin
                        emit  = 1'b1;
                        e_st  = (n_req == '0 && fill_ff == '0) ? ST_EMPTY : ST_OK;
                        e_amt = FIELD_W'(n_req);
                     end else begin
                        // bytes are taken relative to the old read pointer
                        base_in  = rd_ptr_ff;
                        n_in     = n_req;
                        k_in     = '0;
                        state_in = S_RD_ADDR;
                     end
                  end
                  OP_SEARCH: begin
                     if (fill_ff == '0) begin
                        emit = 1'b1;
                        e_st = ST_EMPTY;
                     end else begin
                        cursor_in = cur_eff;
                        if (32'(av) < 32'(len_eff)) begin
                           emit = 1'b1;
                           e_st = ST_NOT_FOUND;
                        end else begin
                           avail_in = av;
                           len_in   = len_eff;
                           pos_in   = '0;
                           state_in = S_SR_ADDR;
                        end
                     end
                  end
                  OP_CLEAR: begin
                     rd_ptr_in = '0;
                     wr_ptr_in = '0;
                     fill_in   = '0;
                     cursor_in = '0;
                     emit      = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RD_ADDR: begin
            mem_re   = 1'b1;
            state_in = S_RD_DATA;
         end
         S_RD_DATA: begin
            if (out_free) begin
               emit   = 1'b1;
               e_byte = rdata_ff;
               e_bv   = 1'b1;
               e_fin  = (k_ff + 1'b1 == n_ff);
               e_amt  = FIELD_W'(n_ff);
               k_in   = k_ff + 1'b1;
               state_in = e_fin ? S_IDLE : S_RD_ADDR;
            end
         end
         S_SR_ADDR: begin
            mem_re    = 1'b1;
            mem_raddr = cursor_ff + pos_ff + 1'b1;
            state_in  = S_SR_DATA;
         end
         S_SR_DATA: begin
            if (out_free) begin
               pos_in = pos_next;
               if (32'(pos_next) >= 32'(len_ff) && hit) begin
                  emit     = 1'b1;
                  e_mo     = sat12(32'(pos_next) - 32'(len_ff) + 32'd1);
                  state_in = S_IDLE;
               end else if (pos_next == avail_ff) begin
                  // keep the last key_len-1 bytes for the next search
                  cursor_in = cursor_ff + avail_ff - PTR_W'(len_ff) + 1'b1;
                  emit      = 1'b1;
                  e_st      = ST_NOT_FOUND;
                  state_in  = S_IDLE;
               end else begin
                  state_in = S_SR_ADDR;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         fill_ff      <= '0;
         cursor_ff    <= '0;
         burst_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         fill_ff   <= fill_in;
         cursor_ff <= cursor_in;
         burst_ff  <= burst_in;
         drop_ff   <= drop_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      base_ff  <= base_in;
      n_ff     <= n_in;
      k_ff     <= k_in;
      pos_ff   <= pos_in;
      avail_ff <= avail_in;
      len_ff   <= len_in;
      if (state_ff == S_SR_DATA && out_free) begin
         win_ff <= win_in;
      end else if (state_ff == S_IDLE) begin
         win_ff <= '0;
      end
      if (emit) begin
         o_byte_ff <= e_byte;
         o_bv_ff   <= e_bv;
         o_fin_ff  <= e_fin;
         o_st_ff   <= e_st;
         o_amt_ff  <= e_amt;
         o_mo_ff   <= e_mo;
         o_fill_ff <= sat12(32'(fill_in));
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= head.entry.data_byte;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.out_byte     = o_byte_ff;
   assign rsp_ch.byte_valid   = o_bv_ff;
   assign rsp_ch.final_item   = o_fin_ff;
   assign rsp_ch.status       = o_st_ff;
   assign rsp_ch.amount       = o_amt_ff;
   assign rsp_ch.match_offset = o_mo_ff;
   assign rsp_ch.fill_count   = o_fill_ff;

endmodule

>>> rtl/core/byte_ring_buffer_with_key_search_core.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_with_key_search_core
// Circular byte buffer with burst writes, read/peek/skip, clear and key search.
// ----------------------------------------------------------------------------
// usage:
//   req_ch carries one command per transfer (write, read, peek, skip, search,
//   clear); rsp_ch returns the results, final_item marking the last one.
//   csr_we/csr_index/csr_wdata set the search key and key length while idle.
// sequencing:
//   a two-entry queue sits behind the request port, so requests are taken
//   while the engine works. a write, clear or skip completes in the idle
//   state; read and peek start in idle, then step through a store read
//   address state and a registered data state per byte; a search starts in
//   idle and steps through a search address state and a data state per
//   scanned byte, up to the unread bytes after the search cursor. the store
//   read path is not pipelined.
// reset:
//   pointers, fill level, cursor and burst count clear; key resets to its
//   default value and length 4. the store itself is not cleared.
// back-pressure:
//   when rsp_ch stalls the engine holds, the queue fills, then req ready drops.
// ----------------------------------------------------------------------------
module byte_ring_buffer_with_key_search_core
   import brbks_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   brbks_req_if.sink            req_ch,
   brbks_rsp_if.source          rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [KEY_W-1:0]     csr_wdata
);

   logic [KEY_W-1:0]  key_bytes_ff;
   logic [KLEN_W-1:0] key_len_ff;
   queue_head_type    head;
   logic              pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_bytes_ff <= KEY_BYTES_RESET;
         key_len_ff   <= KEY_LEN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_KEY_BYTES: key_bytes_ff <= csr_wdata;
            REG_KEY_LEN:   key_len_ff   <= csr_wdata[KLEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   brbks_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .pop    (pop),
      .head   (head)
   );

   brbks_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .key_bytes (key_bytes_ff),
      .key_len   (key_len_ff),
      .rsp_ch    (rsp_ch)
   );

endmodule
